### hdl/bhr_pkg.sv
// ----------------------------------------------------------------------------
// bhr_pkg
// Types and constants shared by the block Hadamard rotation modules.
// ----------------------------------------------------------------------------
package bhr_pkg;

   localparam int XW      = 16;  // Element width, Q8.8.
   localparam int SW      = 16;  // Scale width, Q4.12.
   localparam int EW      = 22;  // Buffer entry width.
   localparam int YW      = 19;  // Result width.
   localparam int KW      = 16;  // Normalization constant width, Q1.15.
   localparam int DIVW    = XW + 12;
   localparam int DIV_STEPS = DIVW;
   localparam int CSR_IW  = 8;
   localparam int CSR_DW  = 8;

   localparam logic [CSR_IW-1:0] CSR_SCALE_ENABLE = 8'd0;
   localparam logic [CSR_IW-1:0] CSR_BLOCK_LOG2   = 8'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_STORE,
      ST_BF_RD,
      ST_BF_SUM,
      ST_BF_DIFF,
      ST_OUT_RD,
      ST_OUT_MUL,
      ST_OUT_LOAD,
      ST_OUT_WAIT
   } bhr_state_type;

   typedef struct packed {
      logic div_start;
      logic div_step;
      logic store_en;
      logic rd_en;
      logic wr_sum;
      logic wr_diff;
      logic mul_en;
      logic out_load;
      logic out_last;
   } bhr_cmd_type;

   // Q1.15 value of 1/sqrt(2^lg), rounded to nearest.
   function automatic logic [KW:0] inv_sqrt_k(input logic [2:0] lg);
      logic [KW:0] k;
      begin
         unique case (lg)
            3'd0:    k = 17'd32768;
            3'd1:    k = 17'd23170;
            3'd2:    k = 17'd16384;
            3'd3:    k = 17'd11585;
            3'd4:    k = 17'd8192;
            3'd5:    k = 17'd5793;
            default: k = 17'd4096;
         endcase
         return k;
      end
   endfunction

endpackage

### hdl/bhr_ctrl.sv
// ----------------------------------------------------------------------------
// bhr_ctrl
// Sequencer: division steps, buffer fill, butterfly passes and result output.
// ----------------------------------------------------------------------------
module bhr_ctrl #(
   parameter int AW = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 scale_enable,
   input  logic [2:0]           eff_lg,
   output bhr_pkg::bhr_cmd_type cmd,
   output logic [AW-1:0]        wr_addr,
   output logic [AW-1:0]        rd_addr_a,
   output logic [AW-1:0]        rd_addr_b
);
   import bhr_pkg::*;

   localparam int DEPTH = 1 << AW;

   bhr_state_type state_ff, state_in;
   logic [AW:0]   fill_ff, fill_in;
   logic [2:0]    stage_ff, stage_in;
   logic [AW-1:0] pair_ff, pair_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [4:0]    cnt_ff, cnt_in;

   logic [AW:0]   n_size;
   logic [AW:0]   fill_next;
   logic [AW-1:0] h_vec;
   logic [AW-1:0] low_mask;
   logic [AW-1:0] j_addr;
   logic          last_pair;
   logic          last_stage;
   logic          last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         stage_ff <= '0;
         pair_ff  <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         stage_ff <= stage_in;
         pair_ff  <= pair_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      n_size     = (AW+1)'(1) << eff_lg;
      fill_next  = fill_ff + 1'b1;
      h_vec      = AW'(1) << stage_ff;
      low_mask   = h_vec - 1'b1;
      // Pair index with a zero inserted at the stage bit gives the upper leg.
      j_addr     = ((pair_ff & ~low_mask) << 1) | (pair_ff & low_mask);
      last_pair  = (pair_ff == AW'((n_size >> 1) - 1'b1));
      last_stage = (stage_ff == (eff_lg - 3'd1));
      last_idx   = ({1'b0, idx_ff} == (n_size - 1'b1));
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      stage_in  = stage_ff;
      pair_in   = pair_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      wr_addr   = fill_ff[AW-1:0];
      rd_addr_a = j_addr;
      rd_addr_b = j_addr | h_vec;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT_WAIT);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = scale_enable ? ST_DIV : ST_STORE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store_en = (fill_ff < (AW+1)'(DEPTH));
            if (fill_next >= n_size) begin
               fill_in  = '0;
               stage_in = '0;
               pair_in  = '0;
               idx_in   = '0;
               state_in = (eff_lg == 3'd0) ? ST_OUT_RD : ST_BF_RD;
            end else begin
               fill_in  = fill_next;
               state_in = ST_IDLE;
            end
         end
         ST_BF_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_BF_SUM;
         end
         ST_BF_SUM: begin
            cmd.wr_sum = 1'b1;
            wr_addr    = j_addr;
            state_in   = ST_BF_DIFF;
         end
         ST_BF_DIFF: begin
            cmd.wr_diff = 1'b1;
            wr_addr     = j_addr | h_vec;
            state_in    = ST_BF_RD;
            if (last_pair) begin
               pair_in = '0;
               if (last_stage) begin
                  state_in = ST_OUT_RD;
               end else begin
                  stage_in = stage_ff + 3'd1;
               end
            end else begin
               pair_in = pair_ff + 1'b1;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr_a = idx_ff;
            state_in  = ST_OUT_MUL;
         end
         ST_OUT_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            cmd.out_load = 1'b1;
            cmd.out_last = last_idx;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               if (last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/bhr_datapath.sv
// ----------------------------------------------------------------------------
// bhr_datapath
// Restoring divider, element buffer, butterfly adder and output scaling.
// ----------------------------------------------------------------------------
module bhr_datapath #(
   parameter int AW = 6
) (
   input  logic                 clock,
   input  bhr_pkg::bhr_cmd_type cmd,
   input  logic [AW-1:0]        wr_addr,
   input  logic [AW-1:0]        rd_addr_a,
   input  logic [AW-1:0]        rd_addr_b,
   input  logic                 scale_enable,
   input  logic [2:0]           eff_lg,
   input  logic signed [15:0]   req_x_value,
   input  logic [15:0]          req_scale_value,
   input  logic                 req_sign_negative,
   output logic signed [18:0]   rsp_y_value,
   output logic                 rsp_last_of_block
);
   import bhr_pkg::*;

   localparam int DEPTH = 1 << AW;
   localparam int PW    = EW + KW + 1;

   logic signed [EW-1:0] mem [DEPTH];

   logic signed [XW-1:0] x_ff;
   logic [SW-1:0]        sc_ff;
   logic                 sgn_ff;
   logic [DIVW-1:0]      quo_ff;
   logic [SW-1:0]        rem_ff;
   logic signed [EW-1:0] rd_a_ff, rd_b_ff, diff_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [YW-1:0] y_ff;
   logic                 last_ff;

   logic [SW:0]          rem_sh;
   logic                 q_bit;
   logic [XW-1:0]        x_mag;
   logic signed [XW-1:0] elem_div;
   logic signed [XW-1:0] elem;
   logic signed [XW-1:0] elem_sgn;
   logic signed [EW-1:0] wr_data;
   logic signed [PW:0]   rounded;
   logic signed [PW-15:0] shifted;
   logic signed [YW-1:0] y_sat;

   always_comb begin
      x_mag  = req_x_value[XW-1] ? XW'(-req_x_value) : XW'(req_x_value);
      rem_sh = {rem_ff, quo_ff[DIVW-1]};
      q_bit  = (rem_sh >= {1'b0, sc_ff});

      if (x_ff == '0) begin
         elem_div = '0;
      end else if (!x_ff[XW-1]) begin
         elem_div = (quo_ff > DIVW'(32767)) ? 16'sd32767 : XW'(quo_ff);
      end else begin
         elem_div = (quo_ff > DIVW'(32768)) ? -16'sd32768 : XW'(-quo_ff);
      end
      elem = scale_enable ? elem_div : x_ff;
      if (sgn_ff) begin
         // Negating the most negative value saturates.
         elem_sgn = (elem == -16'sd32768) ? 16'sd32767 : -elem;
      end else begin
         elem_sgn = elem;
      end

      priority if (cmd.store_en) begin
         wr_data = EW'(elem_sgn);
      end else if (cmd.wr_sum) begin
         wr_data = rd_a_ff + rd_b_ff;
      end else begin
         wr_data = diff_ff;
      end

      rounded = (PW+1)'(prod_ff) + (PW+1)'(16384);
      shifted = rounded[PW:15];
      if (shifted > (PW-14)'(262143)) begin
         y_sat = 19'sh3FFFF;
      end else if (shifted < -(PW-14)'(262144)) begin
         y_sat = 19'sh40000;
      end else begin
         y_sat = YW'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         x_ff   <= req_x_value;
         sc_ff  <= req_scale_value;
         sgn_ff <= req_sign_negative;
         quo_ff <= {x_mag, 12'b0};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[DIVW-2:0], q_bit};
         rem_ff <= q_bit ? SW'(rem_sh - {1'b0, sc_ff}) : SW'(rem_sh);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_en || cmd.wr_sum || cmd.wr_diff) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
      if (cmd.wr_sum) begin
         diff_ff <= rd_a_ff - rd_b_ff;
      end
      if (cmd.mul_en) begin
         prod_ff <= PW'(rd_a_ff) * $signed(inv_sqrt_k(eff_lg));
      end
      if (cmd.out_load) begin
         y_ff    <= y_sat;
         last_ff <= cmd.out_last;
      end
   end

   assign rsp_y_value       = y_ff;
   assign rsp_last_of_block = last_ff;

endmodule

### hdl/block_hadamard_rotate.sv
// ----------------------------------------------------------------------------
// block_hadamard_rotate
// Block Walsh-Hadamard rotation of a scaled, sign-flipped element stream.
// ----------------------------------------------------------------------------
// The req channel takes one element (x_value, scale_value, sign_negative) per
// item; req_stall is high while the block is busy. With scaling on, each
// element runs through a restoring divider before it is stored; a new item
// is accepted only after the last one is stored. Once N = 2^block_log2
// (capped at AW) items are held, log2(N)*N/2 butterflies run through one
// buffer write port, each reading a pair, then writing sum and difference.
// The N results then leave on the rsp channel one at a time (memory read,
// multiply, round and saturate, output register), with last_of_block on the
// final one. A stalled rsp item holds its value until taken; no new input is
// accepted until the whole block has been delivered. Reset clears the fill
// count and the controller, and sets scale_enable to 1 and block_log2 to 6.
// The csr channel is always ready; writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module block_hadamard_rotate #(
   parameter int MAX_BLOCK = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_x_value,
   input  logic [15:0]         req_scale_value,
   input  logic                req_sign_negative,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [18:0]  rsp_y_value,
   output logic                rsp_last_of_block,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [7:0]          csr_data
);
   import bhr_pkg::*;

   localparam int LOG_RAW = $clog2(MAX_BLOCK + 1) - 1;
   localparam int AW      = (LOG_RAW > 6) ? 6 : LOG_RAW;

   logic        scale_enable_ff, scale_enable_in;
   logic [2:0]  block_log2_ff, block_log2_in;
   logic [2:0]  eff_lg;
   bhr_cmd_type cmd;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

   assign csr_ready = 1'b1;

   always_comb begin
      scale_enable_in = scale_enable_ff;
      block_log2_in   = block_log2_ff;
      if (csr_valid) begin
         if (csr_index == CSR_SCALE_ENABLE) begin
            scale_enable_in = csr_data[0];
         end else if (csr_index == CSR_BLOCK_LOG2) begin
            block_log2_in = csr_data[2:0];
         end
      end
      eff_lg = (block_log2_ff > 3'(AW)) ? 3'(AW) : block_log2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_enable_ff <= 1'b1;
         block_log2_ff   <= 3'd6;
      end else begin
         scale_enable_ff <= scale_enable_in;
         block_log2_ff   <= block_log2_in;
      end
   end

   bhr_ctrl #(.AW(AW)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .scale_enable (scale_enable_ff),
      .eff_lg       (eff_lg),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b)
   );

   bhr_datapath #(.AW(AW)) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .wr_addr           (wr_addr),
      .rd_addr_a         (rd_addr_a),
      .rd_addr_b         (rd_addr_b),
      .scale_enable      (scale_enable_ff),
      .eff_lg            (eff_lg),
      .req_x_value       (req_x_value),
      .req_scale_value   (req_scale_value),
      .req_sign_negative (req_sign_negative),
      .rsp_y_value       (rsp_y_value),
      .rsp_last_of_block (rsp_last_of_block)
   );

endmodule
